FILE: hdl/tbef_pkg.sv
// ----------------------------------------------------------------------------
// Three-band energy analyser package
// Shared widths, register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package tbef_pkg;

    localparam int COEFF_W     = 16;
    localparam int HOP_W       = 16;
    localparam int COUNT_W     = 48;
    localparam int SUM_W       = 64;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_COEFF    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_COEFF   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOP_SAMPLES  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_MODE = 8'd3;

    // Reset values of the configuration registers
    localparam logic [COEFF_W-1:0] LOW_COEFF_RST  = 16'd63695;
    localparam logic [COEFF_W-1:0] HIGH_COEFF_RST = 16'd49287;
    localparam logic [HOP_W-1:0]   HOP_RST        = 16'd5513;
    localparam logic               MODE_RST       = 1'b1;

    localparam logic MODE_LEFT    = 1'b0;
    localparam logic MODE_AVERAGE = 1'b1;

    // Band slots of the sums and levels
    localparam logic [1:0] BAND_FULL = 2'd0;
    localparam logic [1:0] BAND_LOW  = 2'd1;
    localparam logic [1:0] BAND_MID  = 2'd2;
    localparam logic [1:0] BAND_HIGH = 2'd3;

    // Filter slots
    localparam logic [1:0] FILT_LOW   = 2'd0;
    localparam logic [1:0] FILT_SPLIT = 2'd1;

    // Half of one Q0.16 unit, for round half up
    localparam int ROUND_HALF = 32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FLT_MUL,
        ST_FLT_UPD,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_COUNT,
        ST_DIV_LOAD,
        ST_DIV,
        ST_SQRT,
        ST_LEVEL,
        ST_EMIT
    } state_t;

endpackage

FILE: hdl/three_band_energy_frame_analyzer_top.sv
// ----------------------------------------------------------------------------
// Three-band energy frame analyser
// Each item runs both filter updates, the four band squares and the frame
// count while in_ready is low. An item that closes a frame then runs a
// 64-step shared divide and a 32-step square root for each of the four bands
// and raises out_valid once the output is free. One item is taken at a time.
// Reset clears filters, sums, counters and out_valid and loads register defaults.
// ----------------------------------------------------------------------------
module three_band_energy_frame_analyzer_top
    import tbef_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int LEVEL_BITS  = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_left,
    input  logic signed [SAMPLE_BITS-1:0] sample_right,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [LEVEL_BITS-1:0]         rms_level,
    output logic [LEVEL_BITS-1:0]         low_level,
    output logic [LEVEL_BITS-1:0]         mid_level,
    output logic [LEVEL_BITS-1:0]         high_level,
    output logic [LEVEL_BITS-1:0]         onset_level,
    output logic [COUNT_W-1:0]            frame_start
);

    localparam int SB     = SAMPLE_BITS;
    localparam int LB     = LEVEL_BITS;
    localparam int MW     = (SB + 2 > COEFF_W + 2) ? SB + 2 : COEFF_W + 2;
    localparam int PW     = 2 * MW;
    localparam int E      = 2 * LB - 2 * (SB - 1);
    localparam int RSH    = (E < 0) ? -E : 0;
    localparam int LSH    = (E > 0) ? E : 0;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int KW     = COEFF_W + 1;

    state_t state_reg, state_next;

    logic [1:0]              idx_reg, idx_next;
    logic [STEP_W-1:0]       step_reg, step_next;

    logic [COEFF_W-1:0]      low_coeff_reg, low_coeff_next;
    logic [COEFF_W-1:0]      high_coeff_reg, high_coeff_next;
    logic [HOP_W-1:0]        hop_reg, hop_next;
    logic                    mode_reg, mode_next;

    logic signed [SB-1:0]    low_flt_reg, low_flt_next;
    logic signed [SB-1:0]    spl_flt_reg, spl_flt_next;
    logic [SUM_W-1:0]        sum_reg [4];
    logic [SUM_W-1:0]        sum_next [4];
    logic [HOP_W-1:0]        frame_count_reg, frame_count_next;
    logic [COUNT_W-1:0]      total_reg, total_next;
    logic [LB-1:0]           last_rms_reg, last_rms_next;
    logic                    out_valid_reg, out_valid_next;

    logic signed [SB-1:0]    x_reg, x_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic [SUM_W-1:0]        q_reg, q_next;
    logic [HOP_W-1:0]        rem_reg, rem_next;
    logic [SUM_W-1:0]        nsq_reg, nsq_next;
    logic [SUM_W-1:0]        res_reg, res_next;
    logic [SUM_W-1:0]        bit_reg, bit_next;
    logic [LB-1:0]           lvl_reg [4];
    logic [LB-1:0]           lvl_next [4];
    logic [LB-1:0]           rms_out_reg, rms_out_next;
    logic [LB-1:0]           low_out_reg, low_out_next;
    logic [LB-1:0]           mid_out_reg, mid_out_next;
    logic [LB-1:0]           high_out_reg, high_out_next;
    logic [LB-1:0]           onset_out_reg, onset_out_next;
    logic [COUNT_W-1:0]      start_out_reg, start_out_next;

    // Mixing and operand selection
    logic signed [SB:0]      lr_sum;
    logic signed [SB-1:0]    mix_val;
    logic signed [SB-1:0]    flt_state;
    logic [COEFF_W-1:0]      flt_coeff;
    logic signed [SB:0]      flt_diff;
    logic [KW-1:0]           k_val;
    logic signed [SB:0]      band_val;
    logic signed [MW-1:0]    mul_a, mul_b;
    logic signed [PW-1:0]    mul_p;

    // Filter update and accumulation
    logic signed [PW-1:0]    flt_round, flt_step, flt_new;
    logic signed [SB-1:0]    flt_upd;
    logic [PW+SUM_W-1:0]     sq_wide;
    logic [SUM_W-1:0]        sq_val;
    logic [SUM_W:0]          acc_sum;
    logic [SUM_W-1:0]        acc_sat;
    logic [HOP_W-1:0]        fc_inc, hop_eff;

    // Shared subtract and compare unit
    logic [HOP_W:0]          div_shift;
    logic [SUM_W-1:0]        sub_a, sub_b;
    logic [SUM_W:0]          sub_diff;
    logic                    sub_ge;
    logic [HOP_W-1:0]        div_rem;
    logic [SUM_W-1:0]        div_q;
    logic                    mean_ovf;
    logic [SUM_W-1:0]        mean_scaled;
    logic [SUM_W-1:0]        root_res, root_rem;
    logic [LB-1:0]           level_val;
    logic                    rise;
    logic [LB-1:0]           rise_diff;
    logic [LB+2:0]           onset_x8;
    logic [LB-1:0]           onset_val;

    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign rms_level      = rms_out_reg;
    assign low_level      = low_out_reg;
    assign mid_level      = mid_out_reg;
    assign high_level     = high_out_reg;
    assign onset_level    = onset_out_reg;
    assign frame_start    = start_out_reg;

    // Mono mix: the floor of the mean is the top bits of the widened sum.
    assign lr_sum  = (SB+1)'(sample_left) + (SB+1)'(sample_right);
    assign mix_val = (mode_reg == MODE_AVERAGE) ? lr_sum[SB:1] : sample_left;

    always_comb
    begin
        flt_state = (idx_reg == FILT_SPLIT) ? spl_flt_reg : low_flt_reg;
        flt_coeff = (idx_reg == FILT_SPLIT) ? high_coeff_reg : low_coeff_reg;
        flt_diff  = (SB+1)'(x_reg) - (SB+1)'(flt_state);
        k_val     = {1'b1, {COEFF_W{1'b0}}} - {1'b0, flt_coeff};

        case (idx_reg)
            BAND_FULL: band_val = (SB+1)'(x_reg);
            BAND_LOW:  band_val = (SB+1)'(low_flt_reg);
            BAND_MID:  band_val = (SB+1)'(spl_flt_reg) - (SB+1)'(low_flt_reg);
            BAND_HIGH: band_val = (SB+1)'(x_reg) - (SB+1)'(spl_flt_reg);
            default:   band_val = (SB+1)'(x_reg);
        endcase

        if (state_reg == ST_SQ_MUL)
        begin
            mul_a = MW'(band_val);
            mul_b = MW'(band_val);
        end
        else
        begin
            mul_a = MW'(flt_diff);
            mul_b = signed'(MW'(k_val));
        end
    end

    // The one multiplier serves both filter updates and all four squares.
    assign mul_p = mul_a * mul_b;

    assign flt_round = prod_reg + PW'(ROUND_HALF);
    assign flt_step  = flt_round >>> COEFF_W;
    assign flt_new   = PW'(flt_state) + flt_step;
    assign flt_upd   = flt_new[SB-1:0];

    // A square that does not fit in the sum width counts as a full sum.
    assign sq_wide = (PW+SUM_W)'(unsigned'(prod_reg));
    assign sq_val  = (|sq_wide[PW+SUM_W-1:SUM_W]) ? '1 : sq_wide[SUM_W-1:0];
    assign acc_sum = {1'b0, sum_reg[idx_reg]} + {1'b0, sq_val};
    assign acc_sat = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];

    assign fc_inc  = (&frame_count_reg) ? frame_count_reg : frame_count_reg + 1'b1;
    assign hop_eff = (hop_reg == '0) ? HOP_W'(1) : hop_reg;

    // Restoring divide shares the subtractor with the square root.
    assign div_shift = {rem_reg, q_reg[SUM_W-1]};

    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            sub_a = nsq_reg;
            sub_b = res_reg + bit_reg;
        end
        else
        begin
            sub_a = SUM_W'(div_shift);
            sub_b = SUM_W'(frame_count_reg);
        end
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = ~sub_diff[SUM_W];

    assign div_rem = sub_ge ? sub_diff[HOP_W-1:0] : div_shift[HOP_W-1:0];
    assign div_q   = {q_reg[SUM_W-2:0], sub_ge};

    // Scale the mean from the sample square scale to the level square scale.
    assign mean_ovf    = (LSH != 0) && ((div_q >> (SUM_W - LSH)) != '0);
    assign mean_scaled = mean_ovf ? '1 : ((div_q >> RSH) << LSH);

    assign root_res = sub_ge ? (res_reg >> 1) + bit_reg : (res_reg >> 1);
    assign root_rem = sub_ge ? sub_diff[SUM_W-1:0] : nsq_reg;

    assign level_val = (|res_reg[SUM_W-1:LB]) ? '1 : res_reg[LB-1:0];

    assign rise      = (lvl_reg[BAND_FULL] > last_rms_reg);
    assign rise_diff = lvl_reg[BAND_FULL] - last_rms_reg;
    assign onset_x8  = {rise_diff, 3'b000};
    assign onset_val = !rise ? '0 : ((|onset_x8[LB+2:LB]) ? '1 : onset_x8[LB-1:0]);

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        step_next        = step_reg;
        low_coeff_next   = low_coeff_reg;
        high_coeff_next  = high_coeff_reg;
        hop_next         = hop_reg;
        mode_next        = mode_reg;
        low_flt_next     = low_flt_reg;
        spl_flt_next     = spl_flt_reg;
        sum_next         = sum_reg;
        frame_count_next = frame_count_reg;
        total_next       = total_reg;
        last_rms_next    = last_rms_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        x_next           = x_reg;
        prod_next        = prod_reg;
        q_next           = q_reg;
        rem_next         = rem_reg;
        nsq_next         = nsq_reg;
        res_next         = res_reg;
        bit_next         = bit_reg;
        lvl_next         = lvl_reg;
        rms_out_next     = rms_out_reg;
        low_out_next     = low_out_reg;
        mid_out_next     = mid_out_reg;
        high_out_next    = high_out_reg;
        onset_out_next   = onset_out_reg;
        start_out_next   = start_out_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LOW_COEFF:    low_coeff_next  = cfg_data[COEFF_W-1:0];
                CFG_HIGH_COEFF:   high_coeff_next = cfg_data[COEFF_W-1:0];
                CFG_HOP_SAMPLES:  hop_next        = cfg_data[HOP_W-1:0];
                CFG_CHANNEL_MODE: mode_next       = cfg_data[0];
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = mix_val;
                    idx_next   = FILT_LOW;
                    state_next = ST_FLT_MUL;
                end
            end
            ST_FLT_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_FLT_UPD;
            end
            ST_FLT_UPD:
            begin
                if (idx_reg == FILT_SPLIT)
                begin
                    spl_flt_next = flt_upd;
                    idx_next     = BAND_FULL;
                    state_next   = ST_SQ_MUL;
                end
                else
                begin
                    low_flt_next = flt_upd;
                    idx_next     = FILT_SPLIT;
                    state_next   = ST_FLT_MUL;
                end
            end
            ST_SQ_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC:
            begin
                sum_next[idx_reg] = acc_sat;
                if (idx_reg == BAND_HIGH)
                begin
                    state_next = ST_COUNT;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_COUNT:
            begin
                frame_count_next = fc_inc;
                total_next       = total_reg + 1'b1;
                if (fc_inc >= hop_eff)
                begin
                    idx_next   = BAND_FULL;
                    state_next = ST_DIV_LOAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_LOAD:
            begin
                q_next     = sum_reg[idx_reg];
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = div_rem;
                q_next    = div_q;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    nsq_next   = mean_scaled;
                    res_next   = '0;
                    bit_next   = SUM_W'(1) << (SUM_W - 2);
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                nsq_next  = root_rem;
                res_next  = root_res;
                bit_next  = bit_reg >> 2;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W / 2 - 1))
                begin
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL:
            begin
                lvl_next[idx_reg] = level_val;
                if (idx_reg == BAND_HIGH)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_EMIT:
            begin
                // Hold the finished frame until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    rms_out_next     = lvl_reg[BAND_FULL];
                    low_out_next     = lvl_reg[BAND_LOW];
                    mid_out_next     = lvl_reg[BAND_MID];
                    high_out_next    = lvl_reg[BAND_HIGH];
                    onset_out_next   = onset_val;
                    start_out_next   = total_reg - COUNT_W'(frame_count_reg);
                    last_rms_next    = lvl_reg[BAND_FULL];
                    frame_count_next = '0;
                    for (int i = 0; i < 4; i++)
                    begin
                        sum_next[i] = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            step_reg        <= '0;
            low_coeff_reg   <= LOW_COEFF_RST;
            high_coeff_reg  <= HIGH_COEFF_RST;
            hop_reg         <= HOP_RST;
            mode_reg        <= MODE_RST;
            low_flt_reg     <= '0;
            spl_flt_reg     <= '0;
            for (int i = 0; i < 4; i++)
            begin
                sum_reg[i] <= '0;
            end
            frame_count_reg <= '0;
            total_reg       <= '0;
            last_rms_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            idx_reg         <= idx_next;
            step_reg        <= step_next;
            low_coeff_reg   <= low_coeff_next;
            high_coeff_reg  <= high_coeff_next;
            hop_reg         <= hop_next;
            mode_reg        <= mode_next;
            low_flt_reg     <= low_flt_next;
            spl_flt_reg     <= spl_flt_next;
            sum_reg         <= sum_next;
            frame_count_reg <= frame_count_next;
            total_reg       <= total_next;
            last_rms_reg    <= last_rms_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        prod_reg      <= prod_next;
        q_reg         <= q_next;
        rem_reg       <= rem_next;
        nsq_reg       <= nsq_next;
        res_reg       <= res_next;
        bit_reg       <= bit_next;
        lvl_reg       <= lvl_next;
        rms_out_reg   <= rms_out_next;
        low_out_reg   <= low_out_next;
        mid_out_reg   <= mid_out_next;
        high_out_reg  <= high_out_next;
        onset_out_reg <= onset_out_next;
        start_out_reg <= start_out_next;
    end

endmodule

FILE: hdl/tbef_checker.sv
// ----------------------------------------------------------------------------
// Three-band energy analyser port checker
// Watches the top level's ports and flags behaviour the block must never show.
// ----------------------------------------------------------------------------
module tbef_checker
    import tbef_pkg::*;
#(
    parameter int LEVEL_BITS  = 16
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [LEVEL_BITS-1:0] rms_level,
    input logic [LEVEL_BITS-1:0] onset_level,
    input logic [COUNT_W-1:0]    frame_start
);

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is still being worked on");

    // A stalled result keeps its value.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(frame_start)
                                       && $stable(rms_level)))
        else $error("stalled result changed or vanished");

    // An onset is a rise in level, so it cannot come with a silent frame.
    a_onset_needs_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && onset_level != '0) |-> (rms_level != '0))
        else $error("onset reported on a silent frame");

    // A frame is only released by the sequencer, never from the idle state.
    a_emit_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while the block was idle");

endmodule

bind three_band_energy_frame_analyzer_top tbef_checker #(
    .LEVEL_BITS  (LEVEL_BITS)
) u_tbef_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Three-band energy frame analyser testbench
// Drives stereo sample items through the valid/ready port, with random bursts
// and gaps on the sender and random back-pressure on the frame output. Every
// accepted item runs through a bit-exact model of the filters, saturating
// sums, frame RMS and onset logic. Each emitted frame is checked field by
// field against the oldest expected frame. A directed table opens the run:
// register extremes, zero hop, filter bypass, mode masking, ignored register
// indexes and a hop lowered in the middle of a frame. Random phases follow,
// each with fresh register values.
// ----------------------------------------------------------------------------
module tb;
    import tbef_pkg::*;

    localparam int SAMPLE_W      = 24;
    localparam int LEVEL_W       = 16;
    localparam int MEAN_SHIFT    = 2 * (SAMPLE_W - 1) - 2 * LEVEL_W;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int SETTLE_CYCLES = 500;
    localparam int IDLE_GUARD    = 200000;

    localparam logic [SAMPLE_W-1:0] S_MAX  = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] S_MIN  = 24'h800000;
    localparam logic [SAMPLE_W-1:0] S_NEG1 = 24'hFFFFFF;

    typedef struct packed {
        logic [LEVEL_W-1:0] rms;
        logic [LEVEL_W-1:0] low;
        logic [LEVEL_W-1:0] mid;
        logic [LEVEL_W-1:0] high;
        logic [LEVEL_W-1:0] onset;
        logic [COUNT_W-1:0] start;
    } frame_t;

    typedef enum logic [0:0] {ROW_CFG, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0]   reg_value;
        logic [SAMPLE_W-1:0]     left;
        logic [SAMPLE_W-1:0]     right;
        logic                    typed;
        frame_t                  want;
    } step_t;

    typedef enum {RX_FREE, RX_CHOPPY, RX_CLOGGED} rx_mode_t;

    localparam frame_t NO_FRAME = '0;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [SAMPLE_W-1:0]    sample_left;
    logic signed [SAMPLE_W-1:0]    sample_right;
    logic                          out_valid;
    logic                          out_ready;
    logic [LEVEL_W-1:0]            rms_level;
    logic [LEVEL_W-1:0]            low_level;
    logic [LEVEL_W-1:0]            mid_level;
    logic [LEVEL_W-1:0]            high_level;
    logic [LEVEL_W-1:0]            onset_level;
    logic [COUNT_W-1:0]            frame_start;

    // Model copy of the registers and of the analyser state
    logic [COEFF_W-1:0] cfg_low  = LOW_COEFF_RST;
    logic [COEFF_W-1:0] cfg_high = HIGH_COEFF_RST;
    logic [HOP_W-1:0]   cfg_hop  = HOP_RST;
    logic               cfg_mode = MODE_RST;

    longint             flt_low      = 0;
    longint             flt_split    = 0;
    logic [SUM_W-1:0]   acc_full     = '0;
    logic [SUM_W-1:0]   acc_low      = '0;
    logic [SUM_W-1:0]   acc_mid      = '0;
    logic [SUM_W-1:0]   acc_high     = '0;
    int unsigned        frame_len    = 0;
    logic [COUNT_W-1:0] sample_total = '0;
    logic [LEVEL_W-1:0] prev_rms     = '0;

    frame_t pending_frames[$];
    int     error_count    = 0;
    int     frames_checked = 0;
    int     items_sent     = 0;
    int     settings_used  = 0;

    step_t directed_steps [30] = '{
        '{ROW_SAMPLE, '0, '0, 24'h000000, 24'h000000, 1'b0, NO_FRAME},
        '{ROW_CFG, CFG_HOP_SAMPLES, 16'd0, '0, '0, 1'b0, NO_FRAME},
        '{ROW_SAMPLE, '0, '0, 24'h000000, 24'h000000, 1'b1,
          '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 48'd0}},
        '{ROW_CFG, CFG_LOW_COEFF, 16'd0, '0, '0, 1'b0, NO_FRAME},
        '{ROW_CFG, CFG_HIGH_COEFF, 16'd0, '0, '0, 1'b0, NO_FRAME},
        // Only bit 0 of the mode value counts, so this selects the left sample.
        '{ROW_CFG, CFG_CHANNEL_MODE, 16'hFFFE, '0, '0, 1'b0, NO_FRAME},
        '{ROW_SAMPLE, '0, '0, S_MAX, S_MIN, 1'b1,
          '{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 48'd2}},
        '{ROW_SAMPLE, '0, '0, S_MIN, 24'h000000, 1'b1,
          '{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 48'd3}},
        '{ROW_CFG, CFG_CHANNEL_MODE, 16'h0001, '0, '0, 1'b0, NO_FRAME},
        '{ROW_SAMPLE, '0, '0, S_MAX, S_MAX, 1'b1,
          '{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 48'd4}},
        // An odd sum in average mode rounds towards minus infinity.
        '{ROW_SAMPLE, '0, '0, S_NEG1, 24'h000000, 1'b1,
          '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 48'd5}},
        '{ROW_SAMPLE, '0, '0, 24'h000001, 24'h000000, 1'b1,
          '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 48'd6}},
        '{ROW_CFG, CFG_LOW_COEFF, 16'hFFFF, '0, '0, 1'b0, NO_FRAME},
        '{ROW_CFG, CFG_HIGH_COEFF, 16'hFFFF, '0, '0, 1'b0, NO_FRAME},
        '{ROW_CFG, CFG_HOP_SAMPLES, 16'd4, '0, '0, 1'b0, NO_FRAME},
        '{ROW_SAMPLE, '0, '0, S_MAX, S_MIN, 1'b0, NO_FRAME},
        '{ROW_SAMPLE, '0, '0, S_MIN, S_MIN, 1'b0, NO_FRAME},
        '{ROW_SAMPLE, '0, '0, 24'h123456, 24'hFF5433, 1'b0, NO_FRAME},
        '{ROW_SAMPLE, '0, '0, 24'h5A5A5A, S_MAX, 1'b0, NO_FRAME},
        '{ROW_CFG, CFG_LOW_COEFF, LOW_COEFF_RST, '0, '0, 1'b0, NO_FRAME},
        '{ROW_CFG, CFG_HIGH_COEFF, HIGH_COEFF_RST, '0, '0, 1'b0, NO_FRAME},
        '{ROW_CFG, CFG_HOP_SAMPLES, 16'hFFFF, '0, '0, 1'b0, NO_FRAME},
        '{ROW_SAMPLE, '0, '0, 24'h400000, 24'hC00000, 1'b0, NO_FRAME},
        '{ROW_SAMPLE, '0, '0, S_MAX, S_MAX, 1'b0, NO_FRAME},
        '{ROW_SAMPLE, '0, '0, 24'hD55556, 24'h155555, 1'b0, NO_FRAME},
        '{ROW_SAMPLE, '0, '0, S_MIN, S_MAX, 1'b0, NO_FRAME},
        // Indexes past the last register must leave every setting alone.
        '{ROW_CFG, 8'd4, 16'hFFFF, '0, '0, 1'b0, NO_FRAME},
        '{ROW_CFG, 8'd255, 16'h0000, '0, '0, 1'b0, NO_FRAME},
        // Lowering the hop below the samples already taken closes the frame on the next item.
        '{ROW_CFG, CFG_HOP_SAMPLES, 16'd3, '0, '0, 1'b0, NO_FRAME},
        '{ROW_SAMPLE, '0, '0, 24'h0F0F0F, 24'hF0F0F1, 1'b0, NO_FRAME}
    };

    three_band_energy_frame_analyzer_top #(
        .SAMPLE_BITS (SAMPLE_W),
        .LEVEL_BITS  (LEVEL_W)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_left    (sample_left),
        .sample_right   (sample_right),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rms_level      (rms_level),
        .low_level      (low_level),
        .mid_level      (mid_level),
        .high_level     (high_level),
        .onset_level    (onset_level),
        .frame_start    (frame_start)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Frame prediction
    // ------------------------------------------------------------------------
    function automatic longint one_pole(longint state, longint x, logic [COEFF_W-1:0] c);
        longint gain;
        gain = 65536 - longint'({48'd0, c});
        return state + (((x - state) * gain + ROUND_HALF) >>> 16);
    endfunction

    function automatic logic [SUM_W-1:0] energy(longint v);
        logic [SUM_W-1:0] mag;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        if (mag > 64'hFFFF_FFFF)
            return '1;
        return mag * mag;
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
        logic [SUM_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[SUM_W] ? '1 : total[SUM_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] band_level(logic [SUM_W-1:0] sum, int unsigned n);
        logic [63:0] mean;
        logic [63:0] root;
        logic [63:0] trial;
        mean = (sum / 64'(n)) >> MEAN_SHIFT;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= mean)
                root = trial;
        end
        return (root > 64'hFFFF) ? '1 : root[LEVEL_W-1:0];
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_LOW_COEFF:    cfg_low  = val;
            CFG_HIGH_COEFF:   cfg_high = val;
            CFG_HOP_SAMPLES:  cfg_hop  = val;
            CFG_CHANNEL_MODE: cfg_mode = val[0];
            default: ;
        endcase
    endfunction

    // Advances the model by one sample item; returns 1 when the item closes a frame.
    function automatic bit analyse_sample(input logic [SAMPLE_W-1:0] l_bits,
                                          input logic [SAMPLE_W-1:0] r_bits,
                                          output frame_t fr);
        longint      left;
        longint      right;
        longint      mono;
        longint      high_band;
        longint      mid_band;
        int unsigned hop_eff;
        int          rise;
        logic [LEVEL_W-1:0] level;
        left  = longint'($signed(l_bits));
        right = longint'($signed(r_bits));
        mono  = (cfg_mode == MODE_AVERAGE) ? ((left + right) >>> 1) : left;
        fr    = '0;

        flt_low   = one_pole(flt_low, mono, cfg_low);
        flt_split = one_pole(flt_split, mono, cfg_high);
        high_band = mono - flt_split;
        mid_band  = flt_split - flt_low;

        acc_full = sat_sum(acc_full, energy(mono));
        acc_low  = sat_sum(acc_low, energy(flt_low));
        acc_mid  = sat_sum(acc_mid, energy(mid_band));
        acc_high = sat_sum(acc_high, energy(high_band));

        if (frame_len < 32'hFFFF)
            frame_len++;
        sample_total = sample_total + 1'b1;

        hop_eff = (cfg_hop == 0) ? 1 : cfg_hop;
        if (frame_len < hop_eff)
            return 1'b0;

        level = band_level(acc_full, frame_len);
        rise  = (int'(level) - int'(prev_rms)) * 8;
        fr.rms   = level;
        fr.low   = band_level(acc_low, frame_len);
        fr.mid   = band_level(acc_mid, frame_len);
        fr.high  = band_level(acc_high, frame_len);
        fr.onset = (rise <= 0) ? '0 : (rise > 65535) ? '1 : rise[LEVEL_W-1:0];
        fr.start = sample_total - COUNT_W'(frame_len);
        prev_rms = level;

        frame_len = 0;
        acc_full  = '0;
        acc_low   = '0;
        acc_mid   = '0;
        acc_high  = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_error(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("frame %0d %s is %0h, expected %0h",
                                   frames_checked, name, got, want));
    endtask

    always @(posedge clk)
    begin : frame_check
        frame_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_frames.size() == 0)
                report_error("frame item arrived with none expected");
            else
            begin
                want = pending_frames.pop_front();
                check_field("rms_level", 64'(rms_level), 64'(want.rms));
                check_field("low_level", 64'(low_level), 64'(want.low));
                check_field("mid_level", 64'(mid_level), 64'(want.mid));
                check_field("high_level", 64'(high_level), 64'(want.high));
                check_field("onset_level", 64'(onset_level), 64'(want.onset));
                check_field("frame_start", 64'(frame_start), 64'(want.start));
                frames_checked++;
            end
        end
    end

    // The frame receiver alternates between free flow, choppy and clogged stretches.
    initial
    begin : frame_receiver
        rx_mode_t rx_mode;
        int       span;
        out_ready = 1'b0;
        forever
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            span    = $urandom_range(20, 200);
            repeat (span)
            begin
                @(negedge clk);
                case (rx_mode)
                    RX_FREE:   out_ready <= 1'b1;
                    RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
                    default:   out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic drive_sample(input logic [SAMPLE_W-1:0] l_bits,
                                input logic [SAMPLE_W-1:0] r_bits,
                                output bit emitted, output frame_t fr);
        @(negedge clk);
        in_valid     <= 1'b1;
        sample_left  <= l_bits;
        sample_right <= r_bits;
        do
            @(posedge clk);
        while (!in_ready);
        emitted = analyse_sample(l_bits, r_bits, fr);
        items_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Lets the block drain every expected frame, then finish any item still in work.
    task automatic wait_idle();
        int guard;
        guard = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_frames.size() != 0 && guard < IDLE_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return COEFF_W'($urandom());
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0:
            begin
                case (raw[1:0])
                    2'd0:    return S_MAX;
                    2'd1:    return S_MIN;
                    2'd2:    return S_NEG1;
                    default: return '0;
                endcase
            end
            1, 2:    return SAMPLE_W'($signed(raw[12:0]));
            default: return raw[SAMPLE_W-1:0];
        endcase
    endfunction

    initial
    begin : stimulus
        frame_t           fr;
        bit               emitted;
        bit               engaged;
        bit               gapless;
        int               burst;
        int               phase_len;
        int               random_items;
        logic [HOP_W-1:0] hop;
        int unsigned      pick;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        sample_left  = '0;
        sample_right = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        engaged      = 1'b0;
        random_items = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == ROW_CFG)
            begin
                if (engaged)
                    wait_idle();
                engaged = 1'b0;
                write_reg(directed_steps[i].reg_index, directed_steps[i].reg_value);
            end
            else
            begin
                drive_sample(directed_steps[i].left, directed_steps[i].right, emitted, fr);
                engaged = 1'b1;
                if (directed_steps[i].typed)
                    pending_frames.insert(pending_frames.size(), directed_steps[i].want);
                else if (emitted)
                    pending_frames.insert(pending_frames.size(), fr);
            end
        end

        // Random phases: every phase starts idle and writes all four registers.
        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            pick = $urandom_range(0, 9);
            if (pick == 0)
                hop = HOP_W'($urandom_range(0, 1));
            else if (pick == 1)
                hop = HOP_W'($urandom_range(100, 400));
            else
                hop = HOP_W'($urandom_range(2, 48));
            write_reg(CFG_LOW_COEFF, pick_coeff());
            write_reg(CFG_HIGH_COEFF, pick_coeff());
            write_reg(CFG_HOP_SAMPLES, hop);
            write_reg(CFG_CHANNEL_MODE, CFG_DATA_W'($urandom()));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom()));
            settings_used++;

            phase_len = (hop <= 1) ? 30 : $urandom_range(80, 300);
            gapless   = ($urandom_range(0, 3) == 0);
            burst     = $urandom_range(1, 40);
            for (int k = 0; k < phase_len && random_items < RANDOM_ITEMS; k++)
            begin
                drive_sample(pick_sample(), pick_sample(), emitted, fr);
                if (emitted)
                    pending_frames.insert(pending_frames.size(), fr);
                random_items++;
                if (!gapless)
                begin
                    burst--;
                    if (burst == 0)
                    begin
                        if ($urandom_range(0, 30) == 0)
                        begin
                            // Hold the sender back until every expected frame has left.
                            @(negedge clk);
                            in_valid <= 1'b0;
                            while (pending_frames.size() != 0)
                                @(posedge clk);
                        end
                        else
                            pause_sender($urandom_range(1, 12));
                        burst = $urandom_range(1, 40);
                    end
                end
            end
        end

        wait_idle();
        if (pending_frames.size() != 0)
            report_error($sformatf("%0d expected frames never arrived",
                                   pending_frames.size()));
        $display("Run covered %0d sample items over %0d random register settings,",
                 items_sent, settings_used);
        $display("with %0d frames checked under random sender gaps and output stalls.",
                 frames_checked);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/tbef_pkg.sv
hdl/three_band_energy_frame_analyzer_top.sv
hdl/tbef_checker.sv
bench/tb.sv
